// File: hw/rtl/pcxrle_pkg.sv
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared types and constants of the run-length palette decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

   localparam int PALETTE_ENTRIES_DEF = 256;
   localparam int MAX_SIDE_DEF        = 1024;

   localparam int SIZE_W     = 11;
   localparam int INDEX_W    = 8;
   localparam int COLOR_W    = 32;
   localparam int CHAN_W     = 8;
   localparam int POS_W      = 20;
   localparam int RUN_W      = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [INDEX_W-1:0] RUN_MARK  = 8'd192;
   localparam logic [CHAN_W-1:0]  MASK_MARK = 8'hAA;

   localparam logic [SIZE_W-1:0]  WIDTH_RST  = 11'd18;
   localparam logic [SIZE_W-1:0]  HEIGHT_RST = 11'd25;
   localparam logic [INDEX_W-1:0] MASK_RST   = 8'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_INDEX   = 2'd2;

   localparam logic OP_STREAM  = 1'b0;
   localparam logic OP_PALETTE = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic pal_write;
      logic set_run;
      logic clear_run;
      logic start_pixels;
      logic pixel_taken;
   } dp_cmd_type;

   typedef struct packed {
      logic is_header;
      logic run_pending;
      logic run_zero;
      logic final_pixel;
   } dp_status_type;

endpackage

// File: hw/rtl/pcxrle_ram.sv
// ----------------------------------------------------------------------------
// pcxrle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcxrle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/pcxrle_ctrl.sv
// ----------------------------------------------------------------------------
// pcxrle_ctrl
// Controller: input and result handshakes, item classification, pixel loop.
// ----------------------------------------------------------------------------
module pcxrle_ctrl
   import pcxrle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_opcode,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           taken;
   logic           can_take;
   logic           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      rsp_valid = (state_ff == ST_EMIT);
      taken     = rsp_valid && !rsp_stall;
      can_take  = (state_ff == ST_IDLE) || (taken && status.final_pixel);
      req_stall = !can_take;
      accept    = req_valid && can_take;

      cmd              = '0;
      cmd.pixel_taken  = taken;
      state_in         = state_ff;

      if (taken && status.final_pixel) begin
         state_in = ST_IDLE;
      end

      if (accept) begin
         if (req_opcode == OP_PALETTE) begin
            cmd.pal_write = 1'b1;
         end else begin
            priority if (status.run_pending && status.run_zero) begin
               cmd.clear_run = 1'b1;
            end else if (!status.run_pending && status.is_header) begin
               cmd.set_run = 1'b1;
            end else begin
               cmd.start_pixels = 1'b1;
               state_in         = ST_EMIT;
            end
         end
      end
   end

   a_emit_accept_only_on_final: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && req_valid && !req_stall) |-> (taken && status.final_pixel))
      else $error("item accepted while pixels remain");

   a_emit_continues: assert property (@(posedge clock) disable iff (reset)
      (taken && !status.final_pixel) |=> rsp_valid)
      else $error("pixel loop stopped early");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.pal_write, cmd.set_run, cmd.clear_run, cmd.start_pixels}))
      else $error("conflicting item commands");

endmodule

// File: hw/rtl/pcxrle_dp.sv
// ----------------------------------------------------------------------------
// pcxrle_dp
// Datapath: configuration, palette memory, run state and pixel counter.
// ----------------------------------------------------------------------------
module pcxrle_dp
   import pcxrle_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
   parameter int MAX_SIDE        = MAX_SIDE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic [INDEX_W-1:0]    req_stream_byte,
   input  logic [INDEX_W-1:0]    req_entry_index,
   input  logic [COLOR_W-1:0]    req_entry_color,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic [CHAN_W-1:0]     rsp_blue,
   output logic [CHAN_W-1:0]     rsp_green,
   output logic [CHAN_W-1:0]     rsp_red,
   output logic [CHAN_W-1:0]     rsp_extra_byte,
   output logic [POS_W-1:0]      rsp_pixel_position,
   output logic                  rsp_last_of_run,
   output logic                  rsp_image_done
);

   localparam int AW   = $clog2(PALETTE_ENTRIES);
   localparam int SW   = $clog2(MAX_SIDE + 1);
   localparam int TW   = 2 * SW;
   localparam int CMPW = (TW > POS_W + 1) ? TW : POS_W + 1;

   logic [SIZE_W-1:0]  width_ff;
   logic [SIZE_W-1:0]  height_ff;
   logic [INDEX_W-1:0] mask_ff;
   logic [TW-1:0]      total_ff;
   logic [TW-1:0]      total_in;
   logic [SW-1:0]      side_w;
   logic [SW-1:0]      side_h;

   logic               pending_ff;
   logic [RUN_W-1:0]   run_len_ff;
   logic [RUN_W-1:0]   remain_ff;
   logic [POS_W-1:0]   cnt_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic               oob_ff;

   logic [POS_W:0]     cnt_next;
   logic               done;
   logic [COLOR_W-1:0] rd_word;
   logic [COLOR_W-1:0] word;
   logic               wr_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         mask_ff   <= MASK_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wr_data;
            CSR_MASK_INDEX:   mask_ff   <= csr_wr_data[INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         side_w = SW'(1);
      end else if (32'(width_ff) > 32'(MAX_SIDE)) begin
         side_w = SW'(MAX_SIDE);
      end else begin
         side_w = SW'(width_ff);
      end
      if (height_ff == '0) begin
         side_h = SW'(1);
      end else if (32'(height_ff) > 32'(MAX_SIDE)) begin
         side_h = SW'(MAX_SIDE);
      end else begin
         side_h = SW'(height_ff);
      end
      total_in = TW'(side_w) * TW'(side_h);
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   assign wr_ok = (9'(req_entry_index) < 9'(PALETTE_ENTRIES));

   pcxrle_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (cmd.pal_write && wr_ok),
      .wr_addr (req_entry_index[AW-1:0]),
      .wr_data (req_entry_color),
      .rd_en   (cmd.start_pixels),
      .rd_addr (req_stream_byte[AW-1:0]),
      .rd_data (rd_word)
   );

   assign cnt_next = {1'b0, cnt_ff} + (POS_W+1)'(1);
   assign done     = CMPW'(cnt_next) >= CMPW'(total_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         run_len_ff <= '0;
         remain_ff  <= '0;
         cnt_ff     <= '0;
      end else begin
         if (cmd.pixel_taken) begin
            cnt_ff    <= done ? '0 : cnt_next[POS_W-1:0];
            remain_ff <= remain_ff - RUN_W'(1);
         end
         if (cmd.set_run) begin
            pending_ff <= 1'b1;
            run_len_ff <= req_stream_byte[RUN_W-1:0];
         end
         if (cmd.clear_run) begin
            pending_ff <= 1'b0;
            run_len_ff <= '0;
         end
         if (cmd.start_pixels) begin
            pending_ff <= 1'b0;
            run_len_ff <= '0;
            remain_ff  <= pending_ff ? run_len_ff : RUN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_pixels) begin
         idx_ff <= req_stream_byte;
         oob_ff <= (9'(req_stream_byte) >= 9'(PALETTE_ENTRIES));
      end
   end

   always_comb begin
      word                = oob_ff ? '0 : rd_word;
      rsp_blue            = word[7:0];
      rsp_green           = word[15:8];
      rsp_red             = word[23:16];
      rsp_extra_byte      = (idx_ff == mask_ff) ? MASK_MARK : word[31:24];
      rsp_pixel_position  = cnt_ff;
      rsp_image_done      = done;
      rsp_last_of_run     = (remain_ff == RUN_W'(1)) || done;

      status.is_header    = (req_stream_byte >= RUN_MARK);
      status.run_pending  = pending_ff;
      status.run_zero     = (run_len_ff == '0);
      status.final_pixel  = rsp_last_of_run;
   end

   a_taken_has_pixels: assert property (@(posedge clock) disable iff (reset)
      cmd.pixel_taken |-> (remain_ff != '0))
      else $error("pixel taken with nothing left");

   a_start_has_pixels: assert property (@(posedge clock) disable iff (reset)
      cmd.start_pixels |=> (remain_ff != '0))
      else $error("pixel loop started empty");

   a_wrap_on_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.pixel_taken && done) |=> (cnt_ff == '0))
      else $error("pixel count did not wrap");

endmodule

// File: hw/rtl/pcx_rle_palette_decoder.sv
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder
// Run-length stream decoder with 256-entry palette lookup and mask marking.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: a palette write (req_opcode = 1) or one byte of
//   the compressed stream (req_opcode = 0). rsp_* delivers the decoded pixels.
//   csr_* writes image width, height and mask index; the user must write
//   them only while the block is idle, as the block does not enforce it. A
//   palette write or a run header gives no pixel. A pixel byte is read from
//   the palette memory in the accept cycle; its first pixel is offered on the
//   next cycle. Runs then give one pixel per cycle while rsp_stall is low,
//   and the input is held until the last pixel of the byte is taken. The
//   next item is accepted in the same cycle the last pixel is taken, so
//   unstalled literals go at one per cycle. The palette read port and the
//   one-pixel-per-cycle loop set this rate. While rsp_stall is high the
//   pixel holds and req_stall stays high. Reset clears run state, pixel
//   count and the configuration to 18 x 25, mask index 1; the palette is not cleared and must be loaded first.
// ----------------------------------------------------------------------------
module pcx_rle_palette_decoder
   import pcxrle_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
   parameter int MAX_SIDE        = MAX_SIDE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [INDEX_W-1:0]    req_stream_byte,
   input  logic [INDEX_W-1:0]    req_entry_index,
   input  logic [COLOR_W-1:0]    req_entry_color,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAN_W-1:0]     rsp_blue,
   output logic [CHAN_W-1:0]     rsp_green,
   output logic [CHAN_W-1:0]     rsp_red,
   output logic [CHAN_W-1:0]     rsp_extra_byte,
   output logic [POS_W-1:0]      rsp_pixel_position,
   output logic                  rsp_last_of_run,
   output logic                  rsp_image_done
);

   dp_cmd_type    cmd;
   dp_status_type status;

   pcxrle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   pcxrle_dp #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .MAX_SIDE        (MAX_SIDE)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_stream_byte    (req_stream_byte),
      .req_entry_index    (req_entry_index),
      .req_entry_color    (req_entry_color),
      .cmd                (cmd),
      .status             (status),
      .rsp_blue           (rsp_blue),
      .rsp_green          (rsp_green),
      .rsp_red            (rsp_red),
      .rsp_extra_byte     (rsp_extra_byte),
      .rsp_pixel_position (rsp_pixel_position),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_image_done     (rsp_image_done)
   );

endmodule
